// ===== design/pia_pkg.sv =====
// Shared types and constants for the process id allocator.
// Used by the controller, the top level and the checker.
// Depends on nothing else.
`timescale 1ns / 1ps

package pia_pkg;

  localparam int ID_PORT_W = 7;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH,
    ST_INSERT
  } state_t;

  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [ID_PORT_W-1:0] id;
  } reply_t;

endpackage

// ===== design/pia_cell.sv =====
// One slot of the id ring: a used flag and the id it holds.
// Takes its neighbor's contents whenever the ring rotates. Uses no package items.
`timescale 1ns / 1ps

module pia_cell #(
  parameter int IdW = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic           nb_used,
  input  logic [IdW-1:0] nb_id,
  output logic           used,
  output logic [IdW-1:0] id
);

  logic           used_r;
  logic [IdW-1:0] id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (shift_en) begin
      used_r <= nb_used;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r <= nb_id;
    end
  end

  assign used = used_r;
  assign id   = id_r;

endmodule

// ===== design/pia_ctrl.sv =====
// Sequencer for the id allocator: watches the head of the slot ring, drives the
// value fed back to its tail, and keeps the last id, safe bound and live count.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_ctrl #(
  parameter int PROC_SLOTS = 64,
  parameter int PID_LIMIT  = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pia_pkg::OP_W-1:0]      in_opcode,
  input  logic [pia_pkg::ID_PORT_W-1:0] in_id_value,
  input  logic                          head_used,
  input  logic [$clog2(PID_LIMIT)-1:0]  head_id,
  output logic                          busy,
  output logic                          shift_en,
  output logic                          fb_used,
  output logic [$clog2(PID_LIMIT)-1:0]  fb_id,
  output pia_pkg::reply_t               reply
);

  localparam int IdW     = $clog2(PID_LIMIT);
  localparam int BndW    = $clog2(PID_LIMIT + 1);
  localparam int CntW    = $clog2(PROC_SLOTS + 1);
  localparam int RunW    = $clog2(PROC_SLOTS);
  localparam int IdPortW = pia_pkg::ID_PORT_W;

  pia_pkg::state_t state_r, state_nxt;
  logic [BndW-1:0] last_r, last_nxt;
  logic [BndW-1:0] bound_r, bound_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [pia_pkg::OP_W-1:0] op_r, op_nxt;
  logic [IdW-1:0] key_r, key_nxt;
  logic [IdPortW-1:0] echo_r, echo_nxt;
  logic [IdW-1:0] cand_r, cand_nxt;
  logic [RunW-1:0] run_r, run_nxt;
  logic [BndW-1:0] min_r, min_nxt;
  logic found_r, found_nxt;
  pia_pkg::reply_t reply_r, reply_nxt;

  logic            accept;
  logic            full;
  logic [31:0]     next_ext;
  logic            fast;
  logic [IdW-1:0]  wrap_cand;
  logic            in_range;
  logic            last_head;
  logic            key_hit;
  logic            hit;
  logic [BndW-1:0] cand_inc_ext;
  logic [IdW-1:0]  cand_inc;
  logic            above;
  logic            found_any;

  assign accept    = start && (state_r == pia_pkg::ST_IDLE);
  assign full      = (32'(count_r) >= 32'(PROC_SLOTS)) || (32'(count_r) >= 32'(PID_LIMIT - 1));
  assign next_ext  = 32'(last_r) + 32'd1;
  assign fast      = (next_ext < 32'(PID_LIMIT)) && (next_ext < 32'(bound_r));
  assign wrap_cand = (next_ext >= 32'(PID_LIMIT)) ? IdW'(1) : IdW'(next_ext);
  assign in_range  = (in_id_value != '0) && (32'(in_id_value) < 32'(PID_LIMIT));
  assign last_head = (run_r == RunW'(PROC_SLOTS - 1));
  assign key_hit   = head_used && (head_id == key_r);
  assign hit       = head_used && (head_id == cand_r);
  assign cand_inc_ext = BndW'(cand_r) + BndW'(1);
  assign cand_inc  = (cand_inc_ext >= BndW'(PID_LIMIT)) ? IdW'(1) : IdW'(cand_inc_ext);
  assign above     = head_used && (head_id > cand_r) && (BndW'(head_id) < min_r);
  assign found_any = found_r || key_hit;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pia_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_opcode == pia_pkg::OP_ALLOC && !full) begin
            state_nxt = fast ? pia_pkg::ST_INSERT : pia_pkg::ST_SEARCH;
          end else if ((in_opcode == pia_pkg::OP_RELEASE || in_opcode == pia_pkg::OP_LOOKUP)
                       && in_range) begin
            state_nxt = pia_pkg::ST_SCAN;
          end
        end
      end
      pia_pkg::ST_SCAN: begin
        if (last_head) begin
          state_nxt = pia_pkg::ST_IDLE;
        end
      end
      pia_pkg::ST_SEARCH: begin
        if (!hit && last_head) begin
          state_nxt = pia_pkg::ST_INSERT;
        end
      end
      pia_pkg::ST_INSERT: begin
        if (!head_used) begin
          state_nxt = pia_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pia_pkg::ST_IDLE;
    endcase
  end

  // Datapath and ring control.
  always_comb begin
    last_nxt  = last_r;
    bound_nxt = bound_r;
    count_nxt = count_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    echo_nxt  = echo_r;
    cand_nxt  = cand_r;
    run_nxt   = run_r;
    min_nxt   = min_r;
    found_nxt = found_r;
    reply_nxt = reply_r;
    reply_nxt.valid = 1'b0;
    fb_used   = head_used;
    fb_id     = head_id;
    shift_en  = (state_r != pia_pkg::ST_IDLE);

    unique case (state_r)
      pia_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_opcode;
          key_nxt  = IdW'(in_id_value);
          echo_nxt = in_id_value;
          cand_nxt = wrap_cand;
          run_nxt  = '0;
          min_nxt  = BndW'(PID_LIMIT);
          found_nxt = 1'b0;
          if (in_opcode == pia_pkg::OP_ALLOC) begin
            if (full) begin
              reply_nxt.valid  = 1'b1;
              reply_nxt.status = pia_pkg::STS_FULL;
              reply_nxt.id     = '0;
            end
          end else if (!((in_opcode == pia_pkg::OP_RELEASE || in_opcode == pia_pkg::OP_LOOKUP)
                         && in_range)) begin
            reply_nxt.valid  = 1'b1;
            reply_nxt.status = pia_pkg::STS_MISS;
            reply_nxt.id     = in_id_value;
          end
        end
      end
      pia_pkg::ST_SCAN: begin
        run_nxt = run_r + RunW'(1);
        if (key_hit) begin
          found_nxt = 1'b1;
          if (op_r == pia_pkg::OP_RELEASE) begin
            fb_used = 1'b0;
          end
        end
        if (last_head) begin
          reply_nxt.valid  = 1'b1;
          reply_nxt.status = found_any ? pia_pkg::STS_OK : pia_pkg::STS_MISS;
          reply_nxt.id     = echo_r;
          if (op_r == pia_pkg::OP_RELEASE && found_any) begin
            count_nxt = count_r - CntW'(1);
          end
        end
      end
      pia_pkg::ST_SEARCH: begin
        // A collision moves the candidate on; it is free once a whole
        // rotation has passed the head without another collision.
        if (hit) begin
          cand_nxt = cand_inc;
          run_nxt  = '0;
          min_nxt  = BndW'(PID_LIMIT);
        end else begin
          run_nxt = run_r + RunW'(1);
          if (above) begin
            min_nxt = BndW'(head_id);
          end
          if (last_head) begin
            bound_nxt = above ? BndW'(head_id) : min_r;
          end
        end
      end
      pia_pkg::ST_INSERT: begin
        if (!head_used) begin
          fb_used   = 1'b1;
          fb_id     = cand_r;
          last_nxt  = BndW'(cand_r);
          count_nxt = count_r + CntW'(1);
          reply_nxt.valid  = 1'b1;
          reply_nxt.status = pia_pkg::STS_OK;
          reply_nxt.id     = IdPortW'(cand_r);
        end
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pia_pkg::ST_IDLE;
      last_r  <= BndW'(PID_LIMIT);
      bound_r <= BndW'(PID_LIMIT);
      count_r <= '0;
      reply_r <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      bound_r <= bound_nxt;
      count_r <= count_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    echo_r  <= echo_nxt;
    cand_r  <= cand_nxt;
    run_r   <= run_nxt;
    min_r   <= min_nxt;
    found_r <= found_nxt;
  end

  assign busy  = (state_r != pia_pkg::ST_IDLE);
  assign reply = reply_r;

endmodule

// ===== design/process_id_allocator_unit.sv =====
// Process id allocator: a ring of PROC_SLOTS slot cells rotated past one head comparator.
// Full table, out-of-range id and unused opcode: strobe in the cycle after start is taken.
// Lookup and release scan one whole rotation. Allocate inserts on the fast path, else
// searches the ring first, restarting the rotation after each collision.
// One transaction at a time; the ring rotates one slot per cycle while busy.
// Synchronous active-low reset empties the table; the first id given is 1.
`timescale 1ns / 1ps

module process_id_allocator_unit #(
  parameter int PROC_SLOTS = 64,
  parameter int PID_LIMIT  = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pia_pkg::OP_W-1:0]      in_opcode,
  input  logic [pia_pkg::ID_PORT_W-1:0] in_id_value,
  output logic                          out_valid,
  output logic [pia_pkg::STATUS_W-1:0]  out_status,
  output logic [pia_pkg::ID_PORT_W-1:0] out_id_result
);

  localparam int IdW = $clog2(PID_LIMIT);

  logic           cell_used [PROC_SLOTS];
  logic [IdW-1:0] cell_id   [PROC_SLOTS];
  logic           shift_en;
  logic           fb_used;
  logic [IdW-1:0] fb_id;
  pia_pkg::reply_t reply;

  pia_ctrl #(
    .PROC_SLOTS (PROC_SLOTS),
    .PID_LIMIT  (PID_LIMIT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_opcode   (in_opcode),
    .in_id_value (in_id_value),
    .head_used   (cell_used[0]),
    .head_id     (cell_id[0]),
    .busy        (busy),
    .shift_en    (shift_en),
    .fb_used     (fb_used),
    .fb_id       (fb_id),
    .reply       (reply)
  );

  // Slot i takes slot i+1 on each rotation; the tail takes the head's updated contents.
  for (genvar i = 0; i < PROC_SLOTS; i++) begin : g_ring
    if (i == PROC_SLOTS - 1) begin : g_tail
      pia_cell #(.IdW(IdW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .nb_used  (fb_used),
        .nb_id    (fb_id),
        .used     (cell_used[i]),
        .id       (cell_id[i])
      );
    end else begin : g_body
      pia_cell #(.IdW(IdW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .nb_used  (cell_used[i+1]),
        .nb_id    (cell_id[i+1]),
        .used     (cell_used[i]),
        .id       (cell_id[i])
      );
    end
  end

  assign out_valid     = reply.valid;
  assign out_status    = reply.status;
  assign out_id_result = reply.id;

endmodule

// ===== design/pia_checker.sv =====
// Port-level checks for the process id allocator, bound to its top level.
// Depends on pia_pkg and process_id_allocator_unit.
`timescale 1ns / 1ps

module pia_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [pia_pkg::OP_W-1:0]      in_opcode,
  input logic [pia_pkg::ID_PORT_W-1:0] in_id_value,
  input logic                          out_valid,
  input logic [pia_pkg::STATUS_W-1:0]  out_status,
  input logic [pia_pkg::ID_PORT_W-1:0] out_id_result
);

  // A result is only presented once the block has gone idle.
  a_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A result strobe accompanies busy falling at the end of a transaction.
  a_done_reply: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // An unused opcode is answered at once with a miss and the echoed id.
  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_opcode == pia_pkg::OP_ALLOC || in_opcode == pia_pkg::OP_RELEASE
                         || in_opcode == pia_pkg::OP_LOOKUP))
    |=> (out_valid && out_status == pia_pkg::STS_MISS
         && out_id_result == $past(in_id_value)))
    else $error("unused opcode not answered as a miss");

  // Id zero is never live.
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_id_value == '0
     && (in_opcode == pia_pkg::OP_RELEASE || in_opcode == pia_pkg::OP_LOOKUP))
    |=> (out_valid && out_status == pia_pkg::STS_MISS))
    else $error("id zero reported as live");

  // A full table always reports id zero.
  a_full_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pia_pkg::STS_FULL) |-> (out_id_result == '0))
    else $error("full status with a nonzero id");

endmodule

bind process_id_allocator_unit pia_checker u_pia_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_opcode     (in_opcode),
  .in_id_value   (in_id_value),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_id_result (out_id_result)
);
